### src/otp_pkg.sv
// ----------------------------------------------------------------------------
// otp_pkg
// Shared types, codes and helpers of the octet text parser.
// ----------------------------------------------------------------------------
package otp_pkg;

    // Largest octet count a string may be asked to carry
    localparam logic [4:0] MAX_OCTETS = 5'd16;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_RADIX_MODE = 2'd0;
    localparam logic [1:0] REG_BYTE_COUNT = 2'd1;
    localparam logic [1:0] REG_SEPARATOR  = 2'd2;

    // Radix mode codes
    localparam logic [1:0] MODE_BIN = 2'd0;
    localparam logic [1:0] MODE_DEC = 2'd1;
    localparam logic [1:0] MODE_HEX = 2'd2;

    // Register reset values
    localparam logic [1:0] RADIX_MODE_RESET = MODE_HEX;
    localparam logic [4:0] BYTE_COUNT_RESET = 5'd6;
    localparam logic [7:0] SEPARATOR_RESET  = 8'd58;

    // Status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_INVALID = 2'd1;
    localparam logic [1:0] STATUS_RANGE   = 2'd2;

    // Character codes
    localparam logic [7:0] CHAR_NUL = 8'h00;

    // Digit value given to anything that is not a digit or a letter
    localparam logic [5:0] DIGIT_NONE = 6'h3F;

    // Flag in the digit counter: separator taken, no digit yet
    localparam logic [3:0] DIGIT_SEP_TAKEN = 4'd8;

    typedef struct packed {
        logic [1:0] radix_mode;
        logic [4:0] byte_count;
        logic [7:0] separator_char;
    } otp_cfg_t;

    typedef struct packed {
        logic       discard;
        logic [4:0] octet_index;
        logic [3:0] digit_index;
        logic [7:0] partial_value;
    } otp_state_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       is_final;
        logic [1:0] status;
        logic [4:0] octets_done;
    } otp_result_t;

    // Map a character to its digit value: decimal digits keep their value,
    // letters of either case continue upwards from ten
    function automatic logic [5:0] char_digit(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'd0;
            if (c >= "0" && c <= "9")
            begin
                d = c - "0";
            end
            else if (c >= "A" && c <= "Z")
            begin
                d = c - "A" + 8'd10;
            end
            else if (c >= "a" && c <= "z")
            begin
                d = c - "a" + 8'd10;
            end
            else
            begin
                d = {2'b00, DIGIT_NONE};
            end
            return d[5:0];
        end
    endfunction

endpackage

### src/otp_if.sv
// ----------------------------------------------------------------------------
// otp_char_if / otp_result_if
// Valid/ready channels for characters in and parse results out.
// ----------------------------------------------------------------------------
interface otp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface otp_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       is_final;
    logic [1:0] status;
    logic [4:0] octets_done;

    modport source (output valid, output byte_value, output is_final,
                    output status, output octets_done, input ready);
    modport sink   (input valid, input byte_value, input is_final,
                    input status, input octets_done, output ready);
endinterface

### src/otp_step.sv
// ----------------------------------------------------------------------------
// otp_step
// Next-state and result logic for one character of the string.
// ----------------------------------------------------------------------------
module otp_step (
    input  logic [7:0]          char_code,
    input  otp_pkg::otp_cfg_t   cfg,
    input  otp_pkg::otp_state_t state,
    output otp_pkg::otp_state_t state_next,
    output logic                emit,
    output otp_pkg::otp_result_t result
);
    import otp_pkg::*;

    logic [4:0]  need;
    logic [5:0]  radix;
    logic [3:0]  field;
    logic [3:0]  count;
    logic [5:0]  digit;
    logic [11:0] scaled;
    logic [11:0] value;
    logic        is_dec;
    logic        fault;
    logic [1:0]  fault_status;

    // Saturate the required octet count
    assign need = (cfg.byte_count > MAX_OCTETS) ? MAX_OCTETS : cfg.byte_count;

    // Select radix and field width, scale the partial value
    always_comb
    begin
        unique case (cfg.radix_mode)
            MODE_BIN:
            begin
                radix  = 6'd2;
                field  = 4'd8;
                scaled = {3'b000, state.partial_value, 1'b0};
            end
            MODE_DEC:
            begin
                radix  = 6'd10;
                field  = 4'd3;
                scaled = {1'b0, state.partial_value, 3'b000}
                       + {3'b000, state.partial_value, 1'b0};
            end
            default:
            begin
                radix  = 6'd16;
                field  = 4'd2;
                scaled = {state.partial_value, 4'b0000};
            end
        endcase
    end

    assign is_dec = (cfg.radix_mode == MODE_DEC);
    assign digit  = char_digit(char_code);
    assign value  = scaled + {6'b000000, digit};
    assign count  = {1'b0, state.digit_index[2:0]} + 4'd1;

    // Walk the string one character at a time
    always_comb
    begin
        state_next   = state;
        emit         = 1'b0;
        result       = '0;
        fault        = 1'b0;
        fault_status = STATUS_OK;

        priority if (state.discard)
        begin
            // swallow up to the terminator, then start afresh
            if (char_code == CHAR_NUL)
            begin
                state_next = '0;
            end
        end
        else if (char_code == CHAR_NUL)
        begin
            state_next      = '0;
            emit            = 1'b1;
            result.is_final = 1'b1;
            if (state.octet_index == need && state.digit_index == 4'd0)
            begin
                result.octets_done = need;
            end
            else
            begin
                result.status = STATUS_INVALID;
            end
        end
        else if (state.octet_index >= need)
        begin
            fault        = 1'b1;
            fault_status = STATUS_INVALID;
        end
        else if (state.digit_index == 4'd0 && state.octet_index != 5'd0
                 && char_code == cfg.separator_char)
        begin
            state_next.digit_index = DIGIT_SEP_TAKEN;
        end
        else if (digit >= radix)
        begin
            fault        = 1'b1;
            fault_status = STATUS_INVALID;
        end
        else if (is_dec && value > 12'd255)
        begin
            fault        = 1'b1;
            fault_status = STATUS_RANGE;
        end
        else if (count >= field)
        begin
            // octet complete: hand it out
            state_next.octet_index   = state.octet_index + 5'd1;
            state_next.digit_index   = 4'd0;
            state_next.partial_value = 8'd0;
            emit                     = 1'b1;
            result.byte_value        = value[7:0];
            result.octets_done       = state.octet_index + 5'd1;
        end
        else
        begin
            state_next.digit_index   = count;
            state_next.partial_value = value[7:0];
        end

        // Report the first fault and drop the rest of the string
        if (fault)
        begin
            state_next         = '0;
            state_next.discard = 1'b1;
            emit               = 1'b1;
            result             = '0;
            result.is_final    = 1'b1;
            result.status      = fault_status;
        end
    end

endmodule

### src/octet_text_parser_core.sv
// ----------------------------------------------------------------------------
// octet_text_parser_core
// Decodes a NUL-terminated character stream into octets with a closing status.
// ----------------------------------------------------------------------------
// A transferred character passes the input register, then the result register.
// Throughput: one character per cycle while the result port is not stalled; the
// input register, one step of decode logic and the result register form the whole path.
// Reset: rst_n clears parse state and the valid flags of both channel registers and
// restores the configuration registers to their defaults; no clearing pass is needed.
module octet_text_parser_core (
    input  logic                clk,
    input  logic                rst_n,
    otp_char_if.sink            chars,
    otp_result_if.source        results,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import otp_pkg::*;

    otp_cfg_t    cfg_reg;
    otp_state_t  state_reg;
    otp_state_t  state_next;
    logic        in_valid_reg;
    logic [7:0]  in_char_reg;
    logic        out_valid_reg;
    otp_result_t out_data_reg;
    otp_result_t step_result;
    logic        step_emit;
    logic        step_fire;
    logic        cfg_write;
    logic [1:0]  reg_index;

    // Configuration port
    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.radix_mode     <= RADIX_MODE_RESET;
            cfg_reg.byte_count     <= BYTE_COUNT_RESET;
            cfg_reg.separator_char <= SEPARATOR_RESET;
        end
        else if (cfg_write)
        begin
            if (reg_index == REG_RADIX_MODE)
            begin
                cfg_reg.radix_mode <= pwdata[1:0];
            end
            if (reg_index == REG_BYTE_COUNT)
            begin
                cfg_reg.byte_count <= pwdata[4:0];
            end
            if (reg_index == REG_SEPARATOR)
            begin
                cfg_reg.separator_char <= pwdata[7:0];
            end
        end
    end

    // Read back the addressed register
    always_comb
    begin
        prdata = 32'd0;
        unique case (reg_index)
            REG_RADIX_MODE: prdata = {30'd0, cfg_reg.radix_mode};
            REG_BYTE_COUNT: prdata = {27'd0, cfg_reg.byte_count};
            REG_SEPARATOR:  prdata = {24'd0, cfg_reg.separator_char};
            default:        prdata = 32'd0;
        endcase
    end

    // Advance a character whenever the result register is free or draining
    assign step_fire   = in_valid_reg && (!out_valid_reg || results.ready);
    assign chars.ready = !in_valid_reg || step_fire;

    // Hold the incoming character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (chars.valid && chars.ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (step_fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            in_char_reg <= chars.char_code;
        end
    end

    otp_step u_step (
        .char_code  (in_char_reg),
        .cfg        (cfg_reg),
        .state      (state_reg),
        .state_next (state_next),
        .emit       (step_emit),
        .result     (step_result)
    );

    // Parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (step_fire)
        begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step_fire)
        begin
            out_valid_reg <= step_emit;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_fire && step_emit)
        begin
            out_data_reg <= step_result;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.byte_value  = out_data_reg.byte_value;
    assign results.is_final    = out_data_reg.is_final;
    assign results.status      = out_data_reg.status;
    assign results.octets_done = out_data_reg.octets_done;

`ifndef SYNTHESIS
    // A byte result always carries ok status
    assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && !results.is_final) |-> (results.status == STATUS_OK))
        else $error("byte result with non-ok status");

    // An error closing result reports no octets
    assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.is_final && results.status != STATUS_OK)
            |-> (results.octets_done == 5'd0))
        else $error("error result with octet count");

    // While swallowing, no progress is kept
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.discard |-> (state_reg.octet_index == 5'd0
                               && state_reg.digit_index == 4'd0
                               && state_reg.partial_value == 8'd0))
        else $error("progress kept while swallowing");

    // A swallowed character never produces a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_fire && state_reg.discard) |=> !results.valid)
        else $error("result produced while swallowing");
`endif

endmodule
